// File: sv/swrms_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the square-root step for the sliding-window RMS color block.
// No dependencies.
package swrms_pkg;

	localparam int CH        = 3;   // channels in one item
	localparam int CH_RED    = 0;
	localparam int CH_GREEN  = 1;
	localparam int CH_BLUE   = 2;

	localparam int PIX_W     = 8;
	localparam int SQ_W      = 16;
	localparam int SUM_W     = 32;
	localparam int ROOT_W    = 16;
	localparam int REM_W     = 19;
	localparam int ITER_W    = 4;
	localparam int LC_W      = 7;
	localparam int IDX_W     = 6;
	localparam int OUT_W     = 8;

	// Reciprocal for the final divide by the window length.
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 24;

	localparam logic [LC_W-1:0] LC_RESET = 7'd16;

	typedef logic [CH-1:0][SUM_W-1:0]  sum_vec_t;
	typedef logic [CH-1:0][PIX_W-1:0]  pix_vec_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_step_t;

	// One restoring square-root step: bring down two radicand bits, try root*4+1.
	function automatic root_step_t root_step(
		input logic [REM_W-1:0]  rem,
		input logic [ROOT_W-1:0] root,
		input logic [1:0]        pair
	);
		logic [REM_W-1:0] part;
		logic [REM_W-1:0] trial;
		root_step_t       r;
		part  = {rem[REM_W-3:0], pair};
		trial = {1'b0, root, 2'b01};
		if (part >= trial) begin
			r.rem  = part - trial;
			r.root = {root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = part;
			r.root = {root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// File: sv/sliding_window_rms_color_top.sv
`timescale 1ns / 1ps
// Sliding-window RMS color filter: sums, ring memory, shared-cycle root and output register.
// Depends on swrms_pkg.
//
// Pixels enter one per cycle while pix_stall is low. Every WINDOW pixels
// close one position; a frame holds light_count + WINDOW - 1 positions. At a
// position end the block holds pix_stall through S_READ to read the ring
// memory and write the new sums back; if the window is full it then runs a
// 16-step restoring square root on all three channels in parallel and one
// multiply stage, and waits in S_OUT for the result register to free up.
// The other WINDOW-1 pixels of a position are taken without a stall. The ring
// needs no clearing pass: a valid bit per entry makes unwritten entries read
// as zero. light_count is loaded when light_count_we is high and used at each
// position end; 0 counts as 1 and values above MAX_LIGHTS count as MAX_LIGHTS.
module sliding_window_rms_color_top #(
	parameter int WINDOW     = 5,
	parameter int MAX_LIGHTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            light_count_we,
	input  logic [swrms_pkg::LC_W-1:0]      light_count,
	// pixel items
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  logic [swrms_pkg::PIX_W-1:0]     pix_blue,
	input  logic [swrms_pkg::PIX_W-1:0]     pix_green,
	input  logic [swrms_pkg::PIX_W-1:0]     pix_red,
	// result items
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [swrms_pkg::OUT_W-1:0]     out_red,
	output logic [swrms_pkg::OUT_W-1:0]     out_green,
	output logic [swrms_pkg::OUT_W-1:0]     out_blue,
	output logic [swrms_pkg::IDX_W-1:0]     light_index,
	output logic                            last_light
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(MAX_LIGHTS + WINDOW);
	localparam int CMP_W  = ((CNT_W > swrms_pkg::LC_W) ? CNT_W : swrms_pkg::LC_W) + 1;
	localparam int PROD_W = swrms_pkg::ROOT_W + swrms_pkg::RECIP_W;
	localparam logic [swrms_pkg::RECIP_W-1:0] RECIP =
		swrms_pkg::RECIP_W'((2 ** swrms_pkg::RECIP_SHIFT + WINDOW - 1) / WINDOW);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_ROOT,
		S_DIV,
		S_OUT
	} state_t;

	state_t                         state_q;
	logic [SLOT_W-1:0]              pip_q;
	logic [SLOT_W-1:0]              slot_q;
	logic [SLOT_W-1:0]              next_slot;
	logic [CNT_W-1:0]               pos_q;
	logic [swrms_pkg::LC_W-1:0]     lc_q;
	logic [WINDOW-1:0]              ring_vld_q;
	logic                           rd_vld_s1;
	logic [swrms_pkg::ITER_W-1:0]   iter_q;
	swrms_pkg::sum_vec_t            sum_q;
	swrms_pkg::sum_vec_t            sum_next;
	swrms_pkg::pix_vec_t            pix_vec;

	// ring memory
	swrms_pkg::sum_vec_t            ring_mem [WINDOW];
	swrms_pkg::sum_vec_t            rd_data_s1;
	logic                           mem_we;
	logic                           rd_en;

	// root datapath
	logic [swrms_pkg::SUM_W-1:0]    rad_q  [swrms_pkg::CH];
	logic [swrms_pkg::REM_W-1:0]    rem_q  [swrms_pkg::CH];
	logic [swrms_pkg::ROOT_W-1:0]   root_q [swrms_pkg::CH];
	logic [PROD_W-1:0]              prod_s [swrms_pkg::CH];
	logic                           last_q;
	logic [swrms_pkg::IDX_W-1:0]    idx_q;

	// output register
	logic                           res_valid_q;
	logic [swrms_pkg::OUT_W-1:0]    res_red_q;
	logic [swrms_pkg::OUT_W-1:0]    res_green_q;
	logic [swrms_pkg::OUT_W-1:0]    res_blue_q;
	logic [swrms_pkg::IDX_W-1:0]    res_idx_q;
	logic                           res_last_q;

	logic                           pix_acc;
	logic                           pos_end;
	logic                           res_free;
	logic [CMP_W-1:0]               lc_wide;
	logic [CMP_W-1:0]               lights;
	logic [CMP_W-1:0]               total;
	logic [CMP_W-1:0]               pos_wide;
	logic                           frame_last;
	logic                           emit;

	assign pix_vec = {pix_blue, pix_green, pix_red};

	assign pix_acc   = pix_valid && (state_q == S_IDLE);
	assign pix_stall = (state_q != S_IDLE);
	assign pos_end   = (pip_q == SLOT_W'(WINDOW - 1));
	assign next_slot = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
	assign res_free  = !res_valid_q || !res_stall;

	// Read the slot about to be replaced at the accept edge; write back in S_READ.
	assign rd_en  = pix_acc && pos_end;
	assign mem_we = (state_q == S_READ);

	// Clamp the light count, then derive the frame length.
	always_comb begin
		lc_wide = CMP_W'(lc_q);
		if (lc_q == '0) begin
			lights = CMP_W'(1);
		end else if (lc_wide > CMP_W'(MAX_LIGHTS)) begin
			lights = CMP_W'(MAX_LIGHTS);
		end else begin
			lights = lc_wide;
		end
		total      = lights + CMP_W'(WINDOW - 1);
		pos_wide   = CMP_W'(pos_q);
		frame_last = (pos_wide + 1'b1) >= total;
		emit       = pos_wide >= CMP_W'(WINDOW - 1);
	end

	// Add the squared channels, wrapping at 32 bits.
	always_comb begin
		for (int c = 0; c < swrms_pkg::CH; c++) begin
			sum_next[c] = sum_q[c] + swrms_pkg::SUM_W'(swrms_pkg::SQ_W'(pix_vec[c]) *
				swrms_pkg::SQ_W'(pix_vec[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[slot_q] <= sum_q;
		end
		if (rd_en) begin
			rd_data_s1 <= ring_mem[next_slot];
		end
	end

	// Control, sums, counters and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pip_q       <= '0;
			slot_q      <= '0;
			pos_q       <= '0;
			lc_q        <= swrms_pkg::LC_RESET;
			ring_vld_q  <= '0;
			rd_vld_s1   <= 1'b0;
			iter_q      <= '0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (light_count_we) begin
				lc_q <= light_count;
			end
			// Drop a taken result; the output state reloads the register itself.
			if (res_valid_q && !res_stall && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pix_acc) begin
						sum_q <= sum_next;
						if (pos_end) begin
							pip_q     <= '0;
							slot_q    <= next_slot;
							rd_vld_s1 <= ring_vld_q[next_slot];
							state_q   <= S_READ;
						end else begin
							pip_q <= pip_q + 1'b1;
						end
					end
				end
				S_READ: begin
					// Sums go to memory this cycle; mark the slot written.
					iter_q <= '0;
					if (frame_last) begin
						pos_q      <= '0;
						slot_q     <= '0;
						sum_q      <= '0;
						// entry 0 reads as zero again in the next frame
						ring_vld_q <= (ring_vld_q | (WINDOW'(1) << slot_q)) & ~WINDOW'(1);
					end else begin
						pos_q      <= pos_q + 1'b1;
						ring_vld_q <= ring_vld_q | (WINDOW'(1) << slot_q);
					end
					state_q <= emit ? S_ROOT : S_IDLE;
				end
				S_ROOT: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == swrms_pkg::ITER_W'(swrms_pkg::ROOT_W - 1)) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Hold until the result register can take the item.
					if (res_free) begin
						res_valid_q <= 1'b1;
						res_red_q   <= prod_s[swrms_pkg::CH_RED][swrms_pkg::RECIP_SHIFT +: swrms_pkg::OUT_W];
						res_green_q <= prod_s[swrms_pkg::CH_GREEN][swrms_pkg::RECIP_SHIFT +: swrms_pkg::OUT_W];
						res_blue_q  <= prod_s[swrms_pkg::CH_BLUE][swrms_pkg::RECIP_SHIFT +: swrms_pkg::OUT_W];
						res_idx_q   <= idx_q;
						res_last_q  <= last_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Root datapath: load the window difference, iterate, then scale by 1/WINDOW.
	// floor(sqrt(d / W^2)) equals floor(isqrt(d) / W).
	always_ff @(posedge clk) begin
		swrms_pkg::root_step_t st;
		if (state_q == S_READ) begin
			for (int c = 0; c < swrms_pkg::CH; c++) begin
				rad_q[c]  <= sum_q[c] - (rd_vld_s1 ? rd_data_s1[c] : '0);
				rem_q[c]  <= '0;
				root_q[c] <= '0;
			end
			last_q <= frame_last;
			idx_q  <= swrms_pkg::IDX_W'(pos_wide - CMP_W'(WINDOW - 1));
		end
		if (state_q == S_ROOT) begin
			for (int c = 0; c < swrms_pkg::CH; c++) begin
				st        = swrms_pkg::root_step(rem_q[c], root_q[c],
					rad_q[c][swrms_pkg::SUM_W-1 -: 2]);
				rem_q[c]  <= st.rem;
				root_q[c] <= st.root;
				rad_q[c]  <= {rad_q[c][swrms_pkg::SUM_W-3:0], 2'b00};
			end
		end
		if (state_q == S_DIV) begin
			for (int c = 0; c < swrms_pkg::CH; c++) begin
				prod_s[c] <= PROD_W'(root_q[c]) * PROD_W'(RECIP);
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign out_red     = res_red_q;
	assign out_green   = res_green_q;
	assign out_blue    = res_blue_q;
	assign light_index = res_idx_q;
	assign last_light  = res_last_q;

`ifndef ASSERT_OFF
	// A position end always goes through the memory write-back cycle.
	ap_pos_end_read: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && pos_end) |=> (state_q == S_READ))
		else $error("position end did not enter write-back");

	// The root runs exactly ROOT_W steps before scaling.
	ap_root_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ($past(state_q) == S_ROOT &&
			$past(iter_q) == swrms_pkg::ITER_W'(swrms_pkg::ROOT_W - 1)))
		else $error("root finished after wrong step count");

	// A new result appears only out of the output state.
	ap_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside output state");

	// A held result is not overwritten while stalled.
	ap_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(out_red) &&
			$stable(light_index) && $stable(last_light)))
		else $error("stalled result changed");

	// Position counter never passes the longest frame.
	ap_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(pos_q) <= CMP_W'(MAX_LIGHTS + WINDOW - 2))
		else $error("position count out of range");
`endif

endmodule
